// File: hdl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared codes and types for the ring buffer deque core and its cells.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // fixed field widths
  localparam int ACT_W = 3;
  localparam int POS_W = 5;
  localparam int ST_W  = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK       = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_right;  // push front: every cell takes its left neighbor
    logic shift_left;   // pop front: every cell takes its right neighbor
    logic write;        // push back: the addressed cell loads the element
  } ctl_t;

endpackage

// File: hdl/rbd_in_if.sv
// ----------------------------------------------------------------------------
// rbd_in_if
// Action channel: valid/ready handshake with action, element and position.
// ----------------------------------------------------------------------------
interface rbd_in_if #(
  parameter int ELEMENT_WIDTH = 32
);
  import rbd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [ELEMENT_WIDTH-1:0] element_in;
  logic signed [POS_W-1:0]  position;

  modport source (output valid, action, element_in, position, input ready);
  modport sink   (input valid, action, element_in, position, output ready);
endinterface

// File: hdl/rbd_out_if.sv
// ----------------------------------------------------------------------------
// rbd_out_if
// Result channel: valid/ready handshake with status, element and occupancy.
// ----------------------------------------------------------------------------
interface rbd_out_if #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int CNT_W         = 5
);
  import rbd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic [ELEMENT_WIDTH-1:0] element_out;
  logic [CNT_W-1:0]         occupancy;

  modport source (output valid, status, element_out, occupancy, input ready);
  modport sink   (input valid, status, element_out, occupancy, output ready);
endinterface

// File: hdl/rbd_cell.sv
// ----------------------------------------------------------------------------
// rbd_cell
// One slot of the deque chain: holds one element, shifts to either neighbor,
// loads on an addressed write and drives its element on an addressed read.
// ----------------------------------------------------------------------------
module rbd_cell #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int IDX_W         = 4,
  parameter int INDEX         = 0
) (
  input  logic                     clk,
  input  rbd_pkg::ctl_t            ctl,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [IDX_W-1:0]         rd_idx,
  input  logic [ELEMENT_WIDTH-1:0] elem_i,
  input  logic [ELEMENT_WIDTH-1:0] left_i,
  input  logic [ELEMENT_WIDTH-1:0] right_i,
  output logic [ELEMENT_WIDTH-1:0] data_o,
  output logic [ELEMENT_WIDTH-1:0] rd_o
);
  import rbd_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [ELEMENT_WIDTH-1:0] data_r;
  logic [ELEMENT_WIDTH-1:0] data_nxt;

  // next slot contents
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_right) begin
      data_nxt = left_i;
    end else if (ctl.shift_left) begin
      data_nxt = right_i;
    end else if (ctl.write && (wr_idx == MY_IDX)) begin
      data_nxt = elem_i;
    end
  end

  // slot register, no reset needed
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // read contribution, zero unless addressed
  assign rd_o   = (rd_idx == MY_IDX) ? data_r : '0;

endmodule

// File: hdl/ring_buffer_deque_core.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque_core
// Fixed-capacity double-ended queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer per action (push back, push front, pop back,
//            pop front, peek). element_in is used by pushes, position by peek;
//            a negative position counts from the back (-1 is the last element).
//   out_ch : exactly one result per action: status, element read and the
//            occupancy after the action. element_out is zero unless a pop or
//            peek returns ok.
// Cell 0 always holds the front element and cell occupancy-1 the back one:
// push front and pop front shift the whole row by one cell, push back writes
// the cell at the occupancy, pop back and peek read one addressed cell.
// The result register shows each result in the cycle after its acceptance.
// Throughput: one action per cycle while results are taken; the output
// register is the only stage, and a new action is taken while the previous
// result is taken downstream. When the receiver stalls, the result holds and
// in_ch.ready drops until the waiting result is transferred.
// Reset empties the queue (occupancy zero) and clears the output valid;
// slot contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
module ring_buffer_deque_core #(
  parameter int DEPTH         = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  rbd_in_if.sink   in_ch,
  rbd_out_if.source out_ch
);
  import rbd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                     accept;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CNT_W-1:0]         cnt_dec;
  ctl_t                     ctl_req;
  ctl_t                     ctl;
  logic [IDX_W-1:0]         wr_idx;
  logic [IDX_W-1:0]         rd_idx;
  logic                     rd_hit;
  logic [ST_W-1:0]          status_nxt;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [PW-1:0]            peek_idx;
  logic                     peek_ok;
  logic [ELEMENT_WIDTH-1:0] cell_q  [DEPTH];
  logic [ELEMENT_WIDTH-1:0] cell_rd [DEPTH];
  logic [ELEMENT_WIDTH-1:0] rd_bus;
  logic [ELEMENT_WIDTH-1:0] elem_nxt;

  logic                     out_valid_r;
  logic [ST_W-1:0]          status_r;
  logic [ELEMENT_WIDTH-1:0] elem_r;
  logic [CNT_W-1:0]         occ_r;

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // peek index, from the front or from the back
  assign cnt_dec  = count_r - 1'b1;
  assign pos_ext  = {{(PW-POS_W){in_ch.position[POS_W-1]}}, in_ch.position};
  assign cnt_ext  = PW'(count_r);
  assign peek_idx = in_ch.position[POS_W-1] ? (cnt_ext + pos_ext) : pos_ext;
  assign peek_ok  = !peek_idx[PW-1] && (peek_idx < cnt_ext);

  // action decode
  always_comb begin
    ctl_req    = '0;
    wr_idx     = count_r[IDX_W-1:0];
    rd_idx     = '0;
    rd_hit     = 1'b0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    case (in_ch.action)
      ACT_PUSH_BACK: begin
        if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_req.write = 1'b1;
          count_nxt     = count_r + 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (count_r == FULL_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_req.shift_right = 1'b1;
          count_nxt           = count_r + 1'b1;
        end
      end
      ACT_POP_BACK: begin
        rd_idx = cnt_dec[IDX_W-1:0];
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_hit    = 1'b1;
          count_nxt = cnt_dec;
        end
      end
      ACT_POP_FRONT: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_hit             = 1'b1;
          ctl_req.shift_left = 1'b1;
          count_nxt          = cnt_dec;
        end
      end
      ACT_PEEK: begin
        rd_idx = peek_idx[IDX_W-1:0];
        if (peek_ok) begin
          rd_hit = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // commands only take effect on an accepted transfer
  assign ctl = accept ? ctl_req : '0;

  // row of cells; cell 0 takes the pushed element on a front shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_d;
    logic [ELEMENT_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_ch.element_in;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    rbd_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH),
      .IDX_W        (IDX_W),
      .INDEX        (i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_idx (wr_idx),
      .rd_idx (rd_idx),
      .elem_i (in_ch.element_in),
      .left_i (left_d),
      .right_i(right_d),
      .data_o (cell_q[i]),
      .rd_o   (cell_rd[i])
    );
  end

  // combine the one addressed cell onto the read bus
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  assign elem_nxt = rd_hit ? rd_bus : '0;

  // occupancy counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      elem_r   <= elem_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.element_out = elem_r;
  assign out_ch.occupancy   = occ_r;

  // occupancy never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("occupancy above capacity");

  // a refused push is only reported with a full queue
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (occ_r == FULL_CNT))
    else $error("full status with room left");

  // no element leaks out with a failing status
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> (elem_r == '0))
    else $error("element returned with non-ok status");

  // a successful pop lowers the occupancy by one
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && count_r != '0 &&
     (in_ch.action == ACT_POP_BACK || in_ch.action == ACT_POP_FRONT))
    |=> (count_r == $past(count_r) - 1'b1))
    else $error("pop did not lower occupancy");

endmodule
